// ----- rtl/pls_pkg.sv -----
// types and codes shared by the positional list store
// no dependencies
`default_nettype none

package pls_pkg;

    typedef enum logic [2:0] {
        MODE_INSERT    = 3'd0,
        MODE_DELETE    = 3'd1,
        MODE_READ      = 3'd2,
        MODE_OVERWRITE = 3'd3,
        MODE_ZERO      = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        logic [2:0]         mode;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] data;
        logic [6:0]         count;
        logic               is_empty;
        logic               is_full;
    } t_rsp;

    localparam logic CAP_REG_ADDR = 1'b0;
    localparam logic [6:0] CAP_RESET = 7'd64;

endpackage

`default_nettype wire

// ----- rtl/pls_cell.sv -----
// one storage cell of the list: holds, loads, shifts from a neighbor or clears
// depends on pls_pkg
`default_nettype none

module pls_cell #(
    parameter int ELEM_WIDTH = 32
) (
    input  wire                   i_clk,
    input  pls_pkg::t_cell_op     i_op,
    input  wire  [ELEM_WIDTH-1:0] i_new,
    input  wire  [ELEM_WIDTH-1:0] i_lower,
    input  wire  [ELEM_WIDTH-1:0] i_upper,
    output logic [ELEM_WIDTH-1:0] o_q
);
    import pls_pkg::*;

    logic [ELEM_WIDTH-1:0] r_q;
    logic [ELEM_WIDTH-1:0] n_q;

    always_comb begin
        case (i_op)
            CELL_HOLD:       n_q = r_q;
            CELL_LOAD:       n_q = i_new;
            CELL_FROM_LOWER: n_q = i_lower;
            CELL_FROM_UPPER: n_q = i_upper;
            CELL_CLEAR:      n_q = '0;
            default:         n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- rtl/positional_list_store.sv -----
// positional list store top: config, request decode, cell row, result register
// depends on pls_pkg and pls_cell
`default_nettype none

// One request is taken per clock (busy stays low) and its result appears on o_rsp,
// strobed by o_rsp_valid, in the cycle after the request is accepted. Every cell of
// the row that must shift, load or clear does so in that same cycle, so inserts
// and deletes cost the same at any position. Results cannot be held off: capture
// them when the strobe is high. Entries come out of reset undefined and need no
// clearing pass; only entries below the count are ever returned. capacity_limit is
// written through the APB port at address 0 and saturates at DEPTH.
module positional_list_store #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  pls_pkg::t_req  i_req,
    output logic           o_busy,
    output logic           o_rsp_valid,
    output pls_pkg::t_rsp  o_rsp,
    input  wire            psel,
    input  wire            penable,
    input  wire            pwrite,
    input  wire  [0:0]     paddr,
    input  wire  [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import pls_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam int CMP_W = (CW > 7) ? CW : 7;
    localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(DEPTH);

    // configuration
    logic [6:0] r_cap;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == CAP_REG_ADDR);
    assign prdata = (paddr == CAP_REG_ADDR) ? {25'd0, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[6:0];
        end
    end

    // request decode
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] n_cnt_x;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cap_x;
    logic             accept;
    logic             do_ins;
    logic             do_del;
    logic             do_rd;
    logic             do_ovr;
    logic             do_zero;
    logic             in_range;
    logic             req_ok;
    logic [ELEM_WIDTH-1:0] new_val;
    logic [ELEM_WIDTH-1:0] rd_q;
    logic [31:0]      rd_data;

    assign o_busy   = 1'b0;
    assign accept   = i_start && !o_busy;
    assign cnt_x    = CMP_W'(r_count);
    assign pos_x    = CMP_W'(i_req.position);
    assign cap_x    = (CMP_W'(r_cap) > DEPTH_X) ? DEPTH_X : CMP_W'(r_cap);
    assign in_range = pos_x < cnt_x;

    always_comb begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_rd   = 1'b0;
        do_ovr  = 1'b0;
        do_zero = 1'b0;
        case (i_req.mode)
            MODE_INSERT:    do_ins  = (cnt_x < cap_x) && (pos_x <= cnt_x);
            MODE_DELETE:    do_del  = in_range;
            MODE_READ:      do_rd   = in_range;
            MODE_OVERWRITE: do_ovr  = in_range;
            MODE_ZERO:      do_zero = 1'b1;
            default:        ;
        endcase
    end

    assign req_ok = do_ins || do_del || do_rd || do_ovr || do_zero;

    always_comb begin
        n_count = r_count;
        if (accept && do_ins) begin
            n_count = r_count + CW'(1);
        end else if (accept && do_del) begin
            n_count = r_count - CW'(1);
        end
    end
    assign n_cnt_x = CMP_W'(n_count);

    generate
        if (ELEM_WIDTH > 32) begin : g_wide_in
            assign new_val = {{(ELEM_WIDTH - 32){i_req.value[31]}}, i_req.value};
        end else begin : g_narrow_in
            assign new_val = i_req.value[ELEM_WIDTH-1:0];
        end
    endgenerate

    // cell row
    logic [ELEM_WIDTH-1:0] cell_q [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam logic [CMP_W-1:0] IDX = CMP_W'(gi);
            t_cell_op              op;
            logic [ELEM_WIDTH-1:0] lower;
            logic [ELEM_WIDTH-1:0] upper;

            if (gi == 0) begin : g_bottom
                assign lower = '0;
            end else begin : g_mid_lo
                assign lower = cell_q[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_top
                assign upper = '0;
            end else begin : g_mid_hi
                assign upper = cell_q[gi+1];
            end

            always_comb begin
                op = CELL_HOLD;
                if (accept) begin
                    if (do_ins && (IDX == pos_x)) begin
                        op = CELL_LOAD;
                    end else if (do_ins && (IDX > pos_x) && (IDX <= cnt_x)) begin
                        op = CELL_FROM_LOWER;
                    end else if (do_del && (IDX >= pos_x) && (IDX + 1'b1 < cnt_x)) begin
                        op = CELL_FROM_UPPER;
                    end else if (do_ovr && (IDX == pos_x)) begin
                        op = CELL_LOAD;
                    end else if (do_zero && (IDX < cnt_x)) begin
                        op = CELL_CLEAR;
                    end
                end
            end

            pls_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_op    (op),
                .i_new   (new_val),
                .i_lower (lower),
                .i_upper (upper),
                .o_q     (cell_q[gi])
            );
        end
    endgenerate

    // read port, valid only when the position is below the count
    assign rd_q = cell_q[pos_x[IW-1:0]];

    generate
        if (ELEM_WIDTH >= 32) begin : g_wide_out
            assign rd_data = rd_q[31:0];
        end else begin : g_narrow_out
            assign rd_data = {{(32 - ELEM_WIDTH){rd_q[ELEM_WIDTH-1]}}, rd_q};
        end
    endgenerate

    // result register
    logic r_valid;
    t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
        if (accept) begin
            r_rsp.ok       <= req_ok;
            r_rsp.data     <= (do_del || do_rd) ? rd_data : 32'sd0;
            r_rsp.count    <= n_cnt_x[6:0];
            r_rsp.is_empty <= (n_count == '0);
            r_rsp.is_full  <= (n_cnt_x >= cap_x);
        end
    end

    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

    // checks
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_rsp_valid)
        else $error("accepted item produced no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= DEPTH_X)
        else $error("entry count exceeds depth");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.ok) |-> (o_rsp.data == 32'sd0))
        else $error("rejected item returned data");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.is_empty == (o_rsp.count == 7'd0)))
        else $error("empty flag disagrees with count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> (r_count == $past(r_count)))
        else $error("count changed without an item");

endmodule

`default_nettype wire

// ----- dv/tb_positional_list_store.sv -----
`timescale 1ns / 1ps
// testbench for positional_list_store: directed table, then random phases at several capacities
// depends on pls_pkg and the rtl of positional_list_store; self-checking against a list model
module tb_positional_list_store;
    import pls_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int TIMEOUT_NS  = 1000000;
    localparam int NUM_PHASES  = 8;

    localparam logic [2:0] MODE_RSVD_5 = 3'd5;
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;

    localparam logic [6:0] CAP_NONE = 7'd0;
    localparam logic [6:0] CAP_ONE  = 7'd1;
    localparam logic [6:0] CAP_FULL = 7'd64;
    localparam logic [6:0] CAP_TOP  = 7'd127;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    t_req        i_req   = '0;
    logic        o_busy;
    logic        o_rsp_valid;
    t_rsp        o_rsp;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [0:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    positional_list_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Verification failed");
        $finish;
    end

    // shadow copy of the list
    logic signed [31:0] list_cells [LIST_DEPTH];
    int                 list_count;
    logic [6:0]         cap_setting;

    t_rsp pending_rsps[$];
    int   mismatch_count;
    bit   item_taken;
    bit   typed_pending;
    t_rsp typed_rsp;

    typedef struct {
        bit         is_cap;
        logic [6:0] cap;
        t_req       req;
        bit         typed;
        t_rsp       rsp;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic int cap_in_force();
        return (cap_setting > LIST_DEPTH) ? LIST_DEPTH : int'(cap_setting);
    endfunction

    task automatic apply_list_op(input t_req r, output t_rsp rsp);
        int pos;
        int cap;
        int i;
        pos = int'(r.position);
        cap = cap_in_force();
        rsp = '0;
        case (r.mode)
            MODE_INSERT: begin
                if (list_count < cap && pos <= list_count) begin
                    for (i = list_count; i > pos; i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[pos] = r.value;
                    list_count++;
                    rsp.ok = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (pos < list_count) begin
                    rsp.data = list_cells[pos];
                    for (i = pos; i + 1 < list_count; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_count--;
                    rsp.ok = 1'b1;
                end
            end
            MODE_READ: begin
                if (pos < list_count) begin
                    rsp.data = list_cells[pos];
                    rsp.ok = 1'b1;
                end
            end
            MODE_OVERWRITE: begin
                if (pos < list_count) begin
                    list_cells[pos] = r.value;
                    rsp.ok = 1'b1;
                end
            end
            MODE_ZERO: begin
                for (i = 0; i < list_count; i++)
                    list_cells[i] = '0;
                rsp.ok = 1'b1;
            end
            default: begin
            end
        endcase
        rsp.count    = 7'(list_count);
        rsp.is_empty = (list_count == 0);
        rsp.is_full  = (list_count >= cap);
    endtask

    task automatic note_mismatch(input bit have_exp, input t_rsp exp);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (!have_exp) begin
                $write("%0t: result with nothing pending: ", $realtime);
                $display("ok=%0b data=%h count=%0d empty=%0b full=%0b",
                         o_rsp.ok, o_rsp.data, o_rsp.count, o_rsp.is_empty,
                         o_rsp.is_full);
            end else begin
                $write("%0t: mismatch exp ok=%0b data=%h count=%0d empty=%0b full=%0b",
                       $realtime, exp.ok, exp.data, exp.count, exp.is_empty, exp.is_full);
                $display(" / got ok=%0b data=%h count=%0d empty=%0b full=%0b",
                         o_rsp.ok, o_rsp.data, o_rsp.count, o_rsp.is_empty, o_rsp.is_full);
            end
        end
    endtask

    // one clock: take the item if accepted, then check any result on the ports
    task automatic tick();
        t_rsp rsp;
        t_rsp exp;
        @(posedge i_clk);
        item_taken = i_start && !o_busy;
        if (item_taken) begin
            apply_list_op(i_req, rsp);
            if (typed_pending) begin
                pending_rsps.push_back(typed_rsp);
                typed_pending = 1'b0;
            end else begin
                pending_rsps.push_back(rsp);
            end
        end
        if (o_rsp_valid === 1'b1) begin
            if (pending_rsps.size() == 0) begin
                note_mismatch(1'b0, '0);
            end else begin
                exp = pending_rsps.pop_front();
                if (o_rsp.ok !== exp.ok || o_rsp.data !== exp.data ||
                    o_rsp.count !== exp.count || o_rsp.is_empty !== exp.is_empty ||
                    o_rsp.is_full !== exp.is_full)
                    note_mismatch(1'b1, exp);
            end
        end
    endtask

    task automatic send_item(input t_req r, input bit use_typed, input t_rsp t);
        typed_pending = use_typed;
        typed_rsp = t;
        i_start <= 1'b1;
        i_req <= r;
        do tick(); while (!item_taken);
    endtask

    task automatic idle_for(input int n);
        i_start <= 1'b0;
        repeat (n) tick();
    endtask

    task automatic write_capacity(input logic [6:0] cap);
        i_start <= 1'b0;
        while (pending_rsps.size() != 0) tick();
        repeat (SETTLE_CYCLES) tick();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_REG_ADDR;
        pwdata <= {25'd0, cap};
        tick();
        penable <= 1'b1;
        do tick(); while (!pready);
        cap_setting = cap;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic void add_row(input logic [2:0] mode, input logic [6:0] pos,
                                    input logic [31:0] val, input bit typed, input t_rsp rsp);
        t_dir_row row;
        row.is_cap = 1'b0;
        row.cap = '0;
        row.req.mode = mode;
        row.req.position = pos;
        row.req.value = val;
        row.typed = typed;
        row.rsp = rsp;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cap_row(input logic [6:0] cap);
        t_dir_row row;
        row.is_cap = 1'b1;
        row.cap = cap;
        row.req = '0;
        row.typed = 1'b0;
        row.rsp = '0;
        dir_rows.push_back(row);
    endfunction

    // filling tides lean on inserts, draining tides on deletes
    function automatic t_req pick_request(input bit filling);
        t_req r;
        int roll;
        int span;
        roll = $urandom_range(99);
        if (roll >= 97)
            r.mode = 3'($urandom_range(MODE_RSVD_5, MODE_RSVD_7));
        else if (filling)
            r.mode = (roll < 50) ? MODE_INSERT : (roll < 65) ? MODE_DELETE :
                     (roll < 82) ? MODE_READ : (roll < 95) ? MODE_OVERWRITE : MODE_ZERO;
        else
            r.mode = (roll < 22) ? MODE_INSERT : (roll < 60) ? MODE_DELETE :
                     (roll < 78) ? MODE_READ : (roll < 95) ? MODE_OVERWRITE : MODE_ZERO;
        span = (r.mode == MODE_INSERT) ? list_count : list_count - 1;
        if (span < 0)
            span = 0;
        if ($urandom_range(99) < 85)
            r.position = 7'($urandom_range(span));
        else
            r.position = 7'($urandom_range(127));
        if ($urandom_range(99) < 85) begin
            r.value = $urandom;
        end else begin
            case ($urandom_range(3))
                0: r.value = 32'h7fff_ffff;
                1: r.value = 32'h8000_0000;
                2: r.value = 32'h0000_0000;
                default: r.value = 32'hffff_ffff;
            endcase
        end
        return r;
    endfunction

    initial begin
        logic [6:0] phase_cap [NUM_PHASES];
        int         phase_items [NUM_PHASES];
        int         idle_pct;
        int         sent;
        int         tide_left;
        bit         filling;
        t_req       req;

        mismatch_count = 0;
        typed_pending = 1'b0;
        list_count = 0;
        cap_setting = CAP_RESET;
        foreach (list_cells[k])
            list_cells[k] = '0;

        // directed table: empty list, extremes, rejects, unused modes, capacity corners
        add_row(MODE_READ, 7'd0, 32'd0, 1, t_rsp'{1'b0, 32'h0, 7'd0, 1'b1, 1'b0});
        add_row(MODE_DELETE, 7'd0, 32'd0, 1, t_rsp'{1'b0, 32'h0, 7'd0, 1'b1, 1'b0});
        add_row(MODE_OVERWRITE, 7'd0, 32'd5, 1, t_rsp'{1'b0, 32'h0, 7'd0, 1'b1, 1'b0});
        add_row(MODE_INSERT, 7'd1, 32'd1, 1, t_rsp'{1'b0, 32'h0, 7'd0, 1'b1, 1'b0});
        add_row(MODE_INSERT, 7'd0, 32'h7fff_ffff, 1, t_rsp'{1'b1, 32'h0, 7'd1, 1'b0, 1'b0});
        add_row(MODE_INSERT, 7'd0, 32'h8000_0000, 1, t_rsp'{1'b1, 32'h0, 7'd2, 1'b0, 1'b0});
        add_row(MODE_INSERT, 7'd2, 32'd1, 0, '0);
        add_row(MODE_READ, 7'd0, 32'd0, 1, t_rsp'{1'b1, 32'h8000_0000, 7'd3, 1'b0, 1'b0});
        add_row(MODE_READ, 7'd127, 32'd0, 1, t_rsp'{1'b0, 32'h0, 7'd3, 1'b0, 1'b0});
        add_row(MODE_OVERWRITE, 7'd1, 32'hffff_ffff, 0, '0);
        add_row(MODE_DELETE, 7'd1, 32'd0, 0, '0);
        add_row(MODE_RSVD_5, 7'd0, 32'd0, 1, t_rsp'{1'b0, 32'h0, 7'd2, 1'b0, 1'b0});
        add_row(MODE_RSVD_7, 7'd127, 32'hffff_ffff, 1, t_rsp'{1'b0, 32'h0, 7'd2, 1'b0, 1'b0});
        add_row(MODE_RSVD_6, 7'd64, 32'd7, 1, t_rsp'{1'b0, 32'h0, 7'd2, 1'b0, 1'b0});
        add_row(MODE_ZERO, 7'd0, 32'd9, 1, t_rsp'{1'b1, 32'h0, 7'd2, 1'b0, 1'b0});
        add_row(MODE_READ, 7'd1, 32'd0, 1, t_rsp'{1'b1, 32'h0, 7'd2, 1'b0, 1'b0});
        add_cap_row(7'd2);
        add_row(MODE_INSERT, 7'd0, 32'h5555_5555, 1, t_rsp'{1'b0, 32'h0, 7'd2, 1'b0, 1'b1});
        add_cap_row(CAP_NONE);
        add_row(MODE_READ, 7'd0, 32'd0, 1, t_rsp'{1'b1, 32'h0, 7'd2, 1'b0, 1'b1});
        add_cap_row(CAP_TOP);
        add_row(MODE_INSERT, 7'd2, 32'haaaa_aaaa, 0, '0);
        add_row(MODE_READ, 7'd2, 32'd0, 0, '0);
        add_row(MODE_DELETE, 7'd64, 32'd0, 1, t_rsp'{1'b0, 32'h0, 7'd3, 1'b0, 1'b0});
        add_cap_row(CAP_ONE);
        add_row(MODE_DELETE, 7'd0, 32'd0, 1, t_rsp'{1'b1, 32'h0, 7'd2, 1'b0, 1'b1});
        add_row(MODE_OVERWRITE, 7'd1, 32'h8000_0000, 0, '0);

        phase_cap = '{CAP_FULL, CAP_ONE, CAP_TOP, 7'd5, 7'($urandom_range(2, 63)), CAP_NONE,
                      7'($urandom_range(65, 126)), CAP_FULL};
        phase_items = '{300, 80, 200, 100, 150, 50, 120, 150};

        repeat (10) tick();
        i_rst_n <= 1'b1;
        tick();

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cap)
                write_capacity(dir_rows[n].cap);
            else
                send_item(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].rsp);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity(phase_cap[ph]);
            // no idling in the last phase, and a quiet phase now and then
            idle_pct = (ph == NUM_PHASES - 1 || ph % 3 == 1) ? 0 : (ph % 3 == 0) ? 12 : 35;
            sent = 0;
            filling = 1'b1;
            tide_left = $urandom_range(120, 220);
            while (sent < phase_items[ph]) begin
                if (tide_left == 0) begin
                    filling = !filling;
                    tide_left = $urandom_range(20, 120);
                end
                tide_left--;
                req = pick_request(filling);
                send_item(req, 1'b0, '0);
                if (req.mode <= MODE_ZERO)
                    sent++;
                if ($urandom_range(99) < idle_pct)
                    idle_for($urandom_range(1, 18));
            end
        end

        i_start <= 1'b0;
        while (pending_rsps.size() != 0) tick();
        repeat (SETTLE_CYCLES) tick();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
